[rtl/agac_pkg.sv]
// agac_pkg: widths, constants, register indexes and shared types of the
// adaptive gain audio clipper.
// No dependencies; used by agac_ctrl, agac_dpath and the top level.
`default_nettype none

package agac_pkg;

   // field widths
   localparam int SAMPLE_W   = 32;
   localparam int GAIN_W     = 17;
   localparam int OUT_W      = 16;
   localparam int PEAK_W     = 15;
   localparam int FRAMES_W   = 13;
   localparam int RETAIN_W   = 8;
   localparam int WEIGHT_W   = 16;
   localparam int SUM_W      = 48;
   localparam int WCOUNT_W   = FRAMES_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // chunk and meter sizing
   localparam int MAX_CHUNK_FRAMES = 4096;
   localparam int PEAK_HISTORY     = 8;
   localparam int HIST_IDX_W       = $clog2(PEAK_HISTORY);
   localparam int HIST_SUM_W       = PEAK_W + HIST_IDX_W;

   // sample scaling
   localparam int FRAC_W = 16;
   localparam int PROD_W = SAMPLE_W + GAIN_W;
   localparam int Q_W    = PROD_W - FRAC_W;

   // weight fraction bits (Q8.8)
   localparam int WEIGHT_FRAC = 8;

   // gain update: partial products and shared divider
   localparam int SLICE_W   = WEIGHT_W;
   localparam int PP_SLICES = SUM_W / SLICE_W;
   localparam int PP_SEL_W  = $clog2(PP_SLICES);
   localparam int ACC_W     = 64;
   localparam int REM_W     = 63;
   localparam int QUO_W     = GAIN_W;
   localparam int DSH_W     = REM_W + QUO_W - 1;
   localparam int CNT_W     = $clog2(QUO_W);

   localparam logic [GAIN_W-1:0]   GAIN_ONE   = GAIN_W'(1) << FRAC_W;
   localparam logic [PEAK_W-1:0]   PEAK_MAX   = '1;
   localparam logic [OUT_W-1:0]    SAMPLE_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0]    SAMPLE_MIN = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic [Q_W-1:0]      POS_LIMIT  = Q_W'(SAMPLE_MAX);
   localparam logic [Q_W-1:0]      NEG_LIMIT  = Q_W'(SAMPLE_MIN);
   localparam logic [FRAMES_W-1:0] FRAMES_MAX = FRAMES_W'(MAX_CHUNK_FRAMES);

   // register reset values
   localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(1024);
   localparam logic [RETAIN_W-1:0] RETAIN_RESET = RETAIN_W'(3);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(256);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RETAIN = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT = CSR_IDX_W'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PP,
      ST_GSETUP,
      ST_GDIV,
      ST_KSETUP,
      ST_KDIV,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic                load;
      logic                eval;
      logic                pp;
      logic [PP_SEL_W-1:0] pp_sel;
      logic                g_setup;
      logic                k_setup;
      logic                div_step;
      logic                finish;
   } dp_cmd_type;

   typedef struct packed {
      logic chunk_end;
      logic prod_ovf;
   } dp_sts_type;

endpackage

`default_nettype wire

[rtl/adaptive_gain_audio_clipper.sv]
// An accepted word is registered in the product stage, then evaluated into
// the result register once it is empty or drained; only then is a new word
// taken. A chunk's last word adds the gain update: partial products, two
// setups, write-back and two 17-step divider passes, one on W*sum overflow.
// Reset (synchronous, active high): gain 1.0, default config, counters clear.
// Top level; depends on agac_pkg, agac_ctrl and agac_dpath.
`default_nettype none

module adaptive_gain_audio_clipper (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [agac_pkg::SAMPLE_W-1:0]  req_mixed_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [agac_pkg::OUT_W-1:0]          rsp_clipped_sample,
   output logic                                       rsp_chunk_end,
   output logic [agac_pkg::PEAK_W-1:0]                rsp_chunk_peak,
   output logic [agac_pkg::PEAK_W-1:0]                rsp_meter_level,
   output logic                                       rsp_meter_valid,
   output logic [agac_pkg::GAIN_W-1:0]                rsp_gain_now,
   input  wire logic                                  csr_write_en,
   input  wire logic [agac_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [agac_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   agac_pkg::dp_cmd_type cmd;
   agac_pkg::dp_sts_type sts;

   // sequencer
   agac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   agac_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_mixed_sample   (req_mixed_sample),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_clipped_sample (rsp_clipped_sample),
      .rsp_chunk_end      (rsp_chunk_end),
      .rsp_chunk_peak     (rsp_chunk_peak),
      .rsp_meter_level    (rsp_meter_level),
      .rsp_meter_valid    (rsp_meter_valid),
      .rsp_gain_now       (rsp_gain_now)
   );

endmodule

`default_nettype wire

[rtl/agac_ctrl.sv]
// agac_ctrl: sequencer of the clipper; takes transactions, times the
// evaluation and the chunk-end gain update, owns the result valid flag.
// Depends on agac_pkg.
`default_nettype none

module agac_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire agac_pkg::dp_sts_type sts,
   output agac_pkg::dp_cmd_type     cmd
);

   agac_pkg::ctrl_state_type state_ff, state_in;
   logic [agac_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic eval_go;

   // result register may be written when empty or being drained
   assign eval_go = !rsp_valid_ff || rsp_ready;

   // next state and step counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         agac_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = agac_pkg::ST_EVAL;
            end
         end
         agac_pkg::ST_EVAL: begin
            if (eval_go) begin
               if (sts.chunk_end) begin
                  state_in = agac_pkg::ST_PP;
                  cnt_in   = agac_pkg::CNT_W'(agac_pkg::PP_SLICES - 1);
               end else begin
                  state_in = agac_pkg::ST_IDLE;
               end
            end
         end
         agac_pkg::ST_PP: begin
            if (cnt_ff == '0) begin
               state_in = agac_pkg::ST_GSETUP;
            end else begin
               cnt_in = cnt_ff - agac_pkg::CNT_W'(1);
            end
         end
         agac_pkg::ST_GSETUP: begin
            if (sts.prod_ovf) begin
               state_in = agac_pkg::ST_KSETUP;
            end else begin
               state_in = agac_pkg::ST_GDIV;
               cnt_in   = agac_pkg::CNT_W'(agac_pkg::QUO_W - 1);
            end
         end
         agac_pkg::ST_GDIV: begin
            if (cnt_ff == '0) begin
               state_in = agac_pkg::ST_KSETUP;
            end else begin
               cnt_in = cnt_ff - agac_pkg::CNT_W'(1);
            end
         end
         agac_pkg::ST_KSETUP: begin
            state_in = agac_pkg::ST_KDIV;
            cnt_in   = agac_pkg::CNT_W'(agac_pkg::QUO_W - 1);
         end
         agac_pkg::ST_KDIV: begin
            if (cnt_ff == '0) begin
               state_in = agac_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff - agac_pkg::CNT_W'(1);
            end
         end
         agac_pkg::ST_FINISH: begin
            state_in = agac_pkg::ST_IDLE;
         end
         default: begin
            state_in = agac_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath commands and input handshake
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         agac_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         agac_pkg::ST_EVAL: begin
            cmd.eval = eval_go;
         end
         agac_pkg::ST_PP: begin
            cmd.pp     = 1'b1;
            cmd.pp_sel = cnt_ff[agac_pkg::PP_SEL_W-1:0];
         end
         agac_pkg::ST_GSETUP: begin
            cmd.g_setup = 1'b1;
         end
         agac_pkg::ST_GDIV, agac_pkg::ST_KDIV: begin
            cmd.div_step = 1'b1;
         end
         agac_pkg::ST_KSETUP: begin
            cmd.k_setup = 1'b1;
         end
         agac_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.eval) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= agac_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // a chunk-end evaluation holds off the next transaction
   a_update_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && sts.chunk_end) |=> !req_ready)
      else $error("input taken during gain update");

   // a result appears only out of an evaluation
   a_valid_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == agac_pkg::ST_EVAL)
      else $error("result valid without evaluation");

   // partial product slice select stays in range
   a_pp_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == agac_pkg::ST_PP) |-> cnt_ff < agac_pkg::CNT_W'(agac_pkg::PP_SLICES))
      else $error("partial product select out of range");
`endif

endmodule

`default_nettype wire

[rtl/agac_dpath.sv]
// agac_dpath: datapath of the clipper; config registers, gain multiply,
// saturation, chunk statistics, peak history and the shared divider.
// Depends on agac_pkg; driven by agac_ctrl.
`default_nettype none

module agac_dpath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire agac_pkg::dp_cmd_type                  cmd,
   output agac_pkg::dp_sts_type                       sts,
   input  wire logic signed [agac_pkg::SAMPLE_W-1:0]  req_mixed_sample,
   input  wire logic                                  csr_write_en,
   input  wire logic [agac_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [agac_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic signed [agac_pkg::OUT_W-1:0]          rsp_clipped_sample,
   output logic                                       rsp_chunk_end,
   output logic [agac_pkg::PEAK_W-1:0]                rsp_chunk_peak,
   output logic [agac_pkg::PEAK_W-1:0]                rsp_meter_level,
   output logic                                       rsp_meter_valid,
   output logic [agac_pkg::GAIN_W-1:0]                rsp_gain_now
);

   localparam int FX_W   = agac_pkg::FRAMES_W + agac_pkg::PEAK_W;
   localparam int D_W    = FX_W + agac_pkg::WEIGHT_FRAC;
   localparam int KR_W   = agac_pkg::GAIN_W + agac_pkg::RETAIN_W;
   localparam int DEN2_W = agac_pkg::RETAIN_W + 1;
   localparam int DIFF_W = agac_pkg::DSH_W + 1;
   localparam int PPP_W  = agac_pkg::WEIGHT_W + agac_pkg::SLICE_W;

   // configuration
   logic [agac_pkg::FRAMES_W-1:0] frames_ff;
   logic [agac_pkg::RETAIN_W-1:0] retain_ff;
   logic [agac_pkg::WEIGHT_W-1:0] weight_ff;

   // block state
   logic [agac_pkg::GAIN_W-1:0]     gain_k_ff, gain_k_in;
   logic [agac_pkg::SUM_W-1:0]      excess_sum_ff, excess_sum_in;
   logic [agac_pkg::PEAK_W-1:0]     running_peak_ff, running_peak_in;
   logic [agac_pkg::WCOUNT_W-1:0]   word_count_ff, word_count_in;
   logic [agac_pkg::PEAK_W-1:0]     hist_ff [agac_pkg::PEAK_HISTORY];
   logic [agac_pkg::HIST_SUM_W-1:0] hist_sum_ff, hist_sum_in;
   logic [agac_pkg::HIST_IDX_W-1:0] chunk_idx_ff, chunk_idx_in;

   // product stage
   logic                          neg_ff;
   logic [agac_pkg::PROD_W-1:0]   prod_ff;

   // gain update working registers
   logic [agac_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [agac_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [agac_pkg::DSH_W-1:0]    dsh_ff, dsh_in;
   logic [agac_pkg::QUO_W-1:0]    quo_ff, quo_in;

   // result registers
   logic [agac_pkg::OUT_W-1:0]    rsp_sample_ff;
   logic                          rsp_end_ff;
   logic [agac_pkg::PEAK_W-1:0]   rsp_peak_ff;
   logic [agac_pkg::PEAK_W-1:0]   rsp_meter_ff;
   logic                          rsp_mvalid_ff;
   logic [agac_pkg::GAIN_W-1:0]   rsp_gain_ff;

   // combinational terms
   logic                          x_neg;
   logic [agac_pkg::SAMPLE_W-1:0] x_mag;
   logic [agac_pkg::PROD_W-1:0]   x_prod;
   logic [agac_pkg::Q_W-1:0]      q;
   logic                          pos_clip, neg_clip;
   logic [agac_pkg::Q_W-1:0]      excess;
   logic [agac_pkg::SUM_W:0]      sum_add;
   logic [agac_pkg::SUM_W-1:0]    sum_sat;
   logic [agac_pkg::OUT_W-1:0]    sample;
   logic [agac_pkg::PEAK_W-1:0]   peak_next;
   logic [agac_pkg::FRAMES_W-1:0] eff_frames;
   logic [agac_pkg::WCOUNT_W:0]   last_word;
   logic                          chunk_end;
   logic                          hist_last;
   logic [agac_pkg::HIST_SUM_W-1:0] hist_sum_next;
   logic [agac_pkg::SUM_W-1:0]    sum_shift;
   logic [PPP_W-1:0]              pp_prod;
   logic                          pp_first;
   logic                          prod_ovf;
   logic [FX_W-1:0]               fx;
   logic [D_W-1:0]                d;
   logic [agac_pkg::REM_W-1:0]    g_den, g_num;
   logic [KR_W-1:0]               kr;
   logic [DEN2_W-1:0]             k_den;
   logic [agac_pkg::REM_W-1:0]    k_num;
   logic [DIFF_W-1:0]             diff;
   logic                          take;

   // sample magnitude times gain, registered at acceptance
   assign x_neg  = req_mixed_sample[agac_pkg::SAMPLE_W-1];
   assign x_mag  = x_neg ? (~req_mixed_sample + agac_pkg::SAMPLE_W'(1)) : req_mixed_sample;
   assign x_prod = agac_pkg::PROD_W'(x_mag) * agac_pkg::PROD_W'(gain_k_ff);

   // saturation and clipped area
   assign q        = prod_ff[agac_pkg::PROD_W-1:agac_pkg::FRAC_W];
   assign pos_clip = !neg_ff && (q > agac_pkg::POS_LIMIT);
   assign neg_clip = neg_ff && (q > agac_pkg::NEG_LIMIT);

   always_comb begin
      priority if (pos_clip) begin
         excess = q - agac_pkg::POS_LIMIT;
         sample = agac_pkg::SAMPLE_MAX;
      end else if (neg_clip) begin
         excess = q - agac_pkg::NEG_LIMIT;
         sample = agac_pkg::SAMPLE_MIN;
      end else if (neg_ff) begin
         excess = '0;
         sample = agac_pkg::OUT_W'(0) - q[agac_pkg::OUT_W-1:0];
      end else begin
         excess = '0;
         sample = q[agac_pkg::OUT_W-1:0];
      end
   end

   // saturating area accumulation
   assign sum_add = {1'b0, excess_sum_ff} + (agac_pkg::SUM_W + 1)'(excess);
   assign sum_sat = sum_add[agac_pkg::SUM_W] ? '1 : sum_add[agac_pkg::SUM_W-1:0];

   // chunk peak
   always_comb begin
      priority if (pos_clip) begin
         peak_next = agac_pkg::PEAK_MAX;
      end else if (!neg_ff && (q > agac_pkg::Q_W'(running_peak_ff))) begin
         peak_next = q[agac_pkg::PEAK_W-1:0];
      end else begin
         peak_next = running_peak_ff;
      end
   end

   // chunk length with out-of-range frame counts clamped
   always_comb begin
      priority if (frames_ff == '0) begin
         eff_frames = agac_pkg::FRAMES_W'(1);
      end else if (frames_ff > agac_pkg::FRAMES_MAX) begin
         eff_frames = agac_pkg::FRAMES_MAX;
      end else begin
         eff_frames = frames_ff;
      end
   end

   assign last_word = {eff_frames, 1'b0} - (agac_pkg::WCOUNT_W + 1)'(1);
   assign chunk_end = (agac_pkg::WCOUNT_W + 1)'(word_count_ff) >= last_word;

   // peak history kept with a running sum
   assign hist_last     = chunk_idx_ff == agac_pkg::HIST_IDX_W'(agac_pkg::PEAK_HISTORY - 1);
   assign hist_sum_next = hist_sum_ff - agac_pkg::HIST_SUM_W'(hist_ff[chunk_idx_ff])
                          + agac_pkg::HIST_SUM_W'(peak_next);

   // weight times area, one 16-bit slice per cycle from the top
   assign sum_shift = excess_sum_ff >> (agac_pkg::SLICE_W * int'(cmd.pp_sel));
   assign pp_prod   = PPP_W'(weight_ff) * PPP_W'(sum_shift[agac_pkg::SLICE_W-1:0]);
   assign pp_first  = cmd.pp_sel == agac_pkg::PP_SEL_W'(agac_pkg::PP_SLICES - 1);
   assign prod_ovf  = acc_ff[agac_pkg::ACC_W-1:agac_pkg::ACC_W-2] != '0;

   // recovery term operands: d = 256 * frames * 32767
   assign fx    = {eff_frames, agac_pkg::PEAK_W'(0)} - FX_W'(eff_frames);
   assign d     = {fx, agac_pkg::WEIGHT_FRAC'(0)};
   assign g_den = agac_pkg::REM_W'(d) + agac_pkg::REM_W'(acc_ff[agac_pkg::ACC_W-3:0]);
   assign g_num = agac_pkg::REM_W'({d, agac_pkg::FRAC_W'(0)}) + (g_den >> 1);

   // new gain operands: (k*R + g + (R+1)/2) / (R+1)
   assign kr    = KR_W'(gain_k_ff) * KR_W'(retain_ff);
   assign k_den = DEN2_W'(retain_ff) + DEN2_W'(1);
   assign k_num = agac_pkg::REM_W'(kr) + agac_pkg::REM_W'(quo_ff)
                  + agac_pkg::REM_W'(k_den >> 1);

   // restoring divider step
   assign diff = DIFF_W'(rem_ff) - DIFF_W'(dsh_ff);
   assign take = !diff[DIFF_W-1];

   // next values of block state
   always_comb begin
      gain_k_in       = gain_k_ff;
      excess_sum_in   = excess_sum_ff;
      running_peak_in = running_peak_ff;
      word_count_in   = word_count_ff;
      hist_sum_in     = hist_sum_ff;
      chunk_idx_in    = chunk_idx_ff;
      if (cmd.eval) begin
         excess_sum_in = sum_sat;
         if (chunk_end) begin
            running_peak_in = '0;
            word_count_in   = '0;
            hist_sum_in     = hist_sum_next;
            chunk_idx_in    = hist_last ? '0 : chunk_idx_ff + agac_pkg::HIST_IDX_W'(1);
         end else begin
            running_peak_in = peak_next;
            word_count_in   = word_count_ff + agac_pkg::WCOUNT_W'(1);
         end
      end
      if (cmd.finish) begin
         gain_k_in     = quo_ff;
         excess_sum_in = '0;
      end
   end

   // next values of the update unit; commands are one-hot, idle cycles hold
   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      if (cmd.pp) begin
         acc_in = (pp_first ? '0 : (acc_ff << agac_pkg::SLICE_W))
                  + agac_pkg::ACC_W'(pp_prod);
      end else if (cmd.g_setup) begin
         rem_in = g_num;
         dsh_in = {g_den, (agac_pkg::QUO_W - 1)'(0)};
         quo_in = '0;
      end else if (cmd.k_setup) begin
         rem_in = k_num;
         dsh_in = agac_pkg::DSH_W'({k_den, (agac_pkg::QUO_W - 1)'(0)});
         quo_in = '0;
      end else if (cmd.div_step) begin
         rem_in = take ? diff[agac_pkg::REM_W-1:0] : rem_ff;
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[agac_pkg::QUO_W-2:0], take};
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= agac_pkg::FRAMES_RESET;
         retain_ff <= agac_pkg::RETAIN_RESET;
         weight_ff <= agac_pkg::WEIGHT_RESET;
      end else if (csr_write_en) begin
         if (csr_index == agac_pkg::CSR_FRAMES) begin
            frames_ff <= csr_wdata[agac_pkg::FRAMES_W-1:0];
         end
         if (csr_index == agac_pkg::CSR_RETAIN) begin
            retain_ff <= csr_wdata[agac_pkg::RETAIN_W-1:0];
         end
         if (csr_index == agac_pkg::CSR_WEIGHT) begin
            weight_ff <= csr_wdata[agac_pkg::WEIGHT_W-1:0];
         end
      end
   end

   // block state
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_k_ff       <= agac_pkg::GAIN_ONE;
         excess_sum_ff   <= '0;
         running_peak_ff <= '0;
         word_count_ff   <= '0;
         hist_sum_ff     <= '0;
         chunk_idx_ff    <= '0;
         for (int i = 0; i < agac_pkg::PEAK_HISTORY; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         gain_k_ff       <= gain_k_in;
         excess_sum_ff   <= excess_sum_in;
         running_peak_ff <= running_peak_in;
         word_count_ff   <= word_count_in;
         hist_sum_ff     <= hist_sum_in;
         chunk_idx_ff    <= chunk_idx_in;
         if (cmd.eval && chunk_end) begin
            hist_ff[chunk_idx_ff] <= peak_next;
         end
      end
   end

   // product stage and update unit
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff  <= x_neg;
         prod_ff <= x_prod;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_end_ff    <= 1'b0;
         rsp_mvalid_ff <= 1'b0;
         rsp_meter_ff  <= '0;
      end else if (cmd.eval) begin
         rsp_end_ff    <= chunk_end;
         rsp_mvalid_ff <= chunk_end && hist_last;
         rsp_meter_ff  <= (chunk_end && hist_last)
                          ? hist_sum_next[agac_pkg::HIST_SUM_W-1:agac_pkg::HIST_IDX_W]
                          : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         rsp_sample_ff <= sample;
         rsp_peak_ff   <= peak_next;
         rsp_gain_ff   <= gain_k_ff;
      end
   end

   assign sts.chunk_end = chunk_end;
   assign sts.prod_ovf  = prod_ovf;

   assign rsp_clipped_sample = rsp_sample_ff;
   assign rsp_chunk_end      = rsp_end_ff;
   assign rsp_chunk_peak     = rsp_peak_ff;
   assign rsp_meter_level    = rsp_meter_ff;
   assign rsp_meter_valid    = rsp_mvalid_ff;
   assign rsp_gain_now       = rsp_gain_ff;

`ifndef SYNTHESIS
   // gain stays within unity
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      gain_k_ff <= agac_pkg::GAIN_ONE)
      else $error("gain above unity");

   // meter level only comes with a chunk end
   a_meter_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_mvalid_ff |-> rsp_end_ff)
      else $error("meter level outside chunk end");

   // meter field is zero when not fresh
   a_meter_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_mvalid_ff |-> rsp_meter_ff == '0)
      else $error("stale meter level");
`endif

endmodule

`default_nettype wire

[dv/tb_top.sv]
// tb_top: self-checking testbench for adaptive_gain_audio_clipper.
// A directed table and a random stream go through a built-in predictor of the
// gain, clipping, chunk and meter logic. Depends on agac_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
   import agac_pkg::*;

   localparam int     CLK_HALF      = 10;
   localparam int     RESET_CYCLES  = 11;
   localparam int     MAX_WAIT      = 19;
   localparam int     RANDOM_ITEMS  = 1500;
   localparam int     SETTLE_CYCLES = 60;
   localparam longint LIMIT_NS      = 20_000_000;
   localparam logic [63:0] AREA_LIMIT = (64'd1 << SUM_W) - 64'd1;

   typedef struct packed {
      logic signed [OUT_W-1:0] clipped;
      logic                    chunk_end;
      logic [PEAK_W-1:0]       peak;
      logic [PEAK_W-1:0]       meter;
      logic                    meter_valid;
      logic [GAIN_W-1:0]       gain;
   } clip_result_t;

   typedef enum logic [1:0] {ROW_SAMPLE, ROW_TYPED, ROW_CSR} row_kind_t;

   typedef struct packed {
      row_kind_t              kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [SAMPLE_W-1:0]    value;
      clip_result_t           typed;
   } stim_row_t;

   // block ports
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic signed [SAMPLE_W-1:0]  req_mixed_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]     rsp_clipped_sample;
   logic                        rsp_chunk_end;
   logic [PEAK_W-1:0]           rsp_chunk_peak;
   logic [PEAK_W-1:0]           rsp_meter_level;
   logic                        rsp_meter_valid;
   logic [GAIN_W-1:0]           rsp_gain_now;
   logic                        csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   // predictor state and register copies
   logic [FRAMES_W-1:0]   cfg_frames = FRAMES_RESET;
   logic [RETAIN_W-1:0]   cfg_retain = RETAIN_RESET;
   logic [WEIGHT_W-1:0]   cfg_weight = WEIGHT_RESET;
   logic [GAIN_W-1:0]     gain_q = GAIN_ONE;
   logic [SUM_W-1:0]      clip_area = '0;
   logic [PEAK_W-1:0]     peak_now = '0;
   logic [WCOUNT_W-1:0]   words_in_chunk = '0;
   logic [PEAK_W-1:0]     peak_log [PEAK_HISTORY];
   logic [HIST_IDX_W-1:0] chunk_count = '0;

   clip_result_t expected_outputs [$];
   stim_row_t    stim_table [$];

   // bookkeeping
   int  mismatches = 0;
   int  items_sent = 0;
   int  directed_items = 0;
   int  results_seen = 0;
   int  chunk_ends = 0;
   int  meter_updates = 0;
   int  saturated = 0;
   int  cfg_writes = 0;
   bit  req_quiet = 1'b0;
   bit  rsp_quiet = 1'b0;

   adaptive_gain_audio_clipper dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mixed_sample   (req_mixed_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_clipped_sample (rsp_clipped_sample),
      .rsp_chunk_end      (rsp_chunk_end),
      .rsp_chunk_peak     (rsp_chunk_peak),
      .rsp_meter_level    (rsp_meter_level),
      .rsp_meter_valid    (rsp_meter_valid),
      .rsp_gain_now       (rsp_gain_now),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #(CLK_HALF) clock = ~clock;

   // gain recovery term blended with the old gain at chunk end
   function automatic logic [GAIN_W-1:0] next_gain_value(logic [63:0] frames);
      logic [63:0] d;
      logic [63:0] prod;
      logic [63:0] den;
      logic [63:0] g;
      logic [63:0] r;
      d    = 64'd256 * frames * 64'd32767;
      prod = 64'(cfg_weight) * 64'(clip_area);
      r    = 64'(cfg_retain);
      if (prod >= (64'd1 << 62)) begin
         g = 64'd0;
      end else begin
         den = d + prod;
         g   = (64'd65536 * d + den / 64'd2) / den;
      end
      return GAIN_W'((64'(gain_q) * r + g + (r + 64'd1) / 64'd2) / (r + 64'd1));
   endfunction

   // scale one word, saturate, and advance the chunk and meter state
   function automatic clip_result_t scale_and_track(logic [SAMPLE_W-1:0] sample);
      clip_result_t res;
      logic         neg;
      logic [63:0]  mag;
      logic [63:0]  q;
      logic [63:0]  excess;
      logic [63:0]  area;
      logic [63:0]  frames;
      logic [63:0]  hist_sum;
      res    = '0;
      neg    = sample[SAMPLE_W-1];
      mag    = neg ? (64'd1 << SAMPLE_W) - 64'(sample) : 64'(sample);
      q      = (mag * 64'(gain_q)) >> FRAC_W;
      excess = 64'd0;
      if (!neg && q > 64'd32767) begin
         excess      = q - 64'd32767;
         res.clipped = SAMPLE_MAX;
         peak_now    = PEAK_MAX;
      end else if (neg && q > 64'd32768) begin
         excess      = q - 64'd32768;
         res.clipped = SAMPLE_MIN;
      end else begin
         res.clipped = neg ? OUT_W'(64'd0 - q) : OUT_W'(q);
         if (!neg && q > 64'(peak_now)) peak_now = PEAK_W'(q);
      end
      area      = 64'(clip_area) + excess;
      clip_area = (area > AREA_LIMIT) ? SUM_W'(AREA_LIMIT) : SUM_W'(area);
      res.peak  = peak_now;
      res.gain  = gain_q;

      // zero frames acts as one, oversize clamps to the maximum chunk
      if (cfg_frames == '0) frames = 64'd1;
      else if (cfg_frames > FRAMES_MAX) frames = 64'(MAX_CHUNK_FRAMES);
      else frames = 64'(cfg_frames);

      // a shrunk chunk ends on the first word at or past its last slot
      res.chunk_end = (64'(words_in_chunk) >= 64'd2 * frames - 64'd1);
      if (res.chunk_end) begin
         gain_q                = next_gain_value(frames);
         peak_log[chunk_count] = peak_now;
         chunk_count           = chunk_count + 1'b1;
         if (chunk_count == '0) begin
            hist_sum = 64'd0;
            for (int i = 0; i < PEAK_HISTORY; i++) hist_sum += 64'(peak_log[i]);
            res.meter       = PEAK_W'(hist_sum / PEAK_HISTORY);
            res.meter_valid = 1'b1;
         end
         clip_area      = '0;
         peak_now       = '0;
         words_in_chunk = '0;
      end else begin
         words_in_chunk = words_in_chunk + 1'b1;
      end
      return res;
   endfunction

   // expectation for the opening rows: gain 1.0, mid-chunk, no meter
   function automatic clip_result_t unity_result(int clipped, int peak);
      clip_result_t res;
      res         = '0;
      res.clipped = OUT_W'(clipped);
      res.peak    = PEAK_W'(peak);
      res.gain    = GAIN_ONE;
      return res;
   endfunction

   function automatic void add_row(row_kind_t kind, logic [CSR_IDX_W-1:0] idx,
                                   logic [SAMPLE_W-1:0] value, clip_result_t typed);
      stim_row_t row;
      row.kind  = kind;
      row.idx   = idx;
      row.value = value;
      row.typed = typed;
      stim_table.push_back(row);
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0, 1, 2: return SAMPLE_W'($urandom_range(0, 65535)) - 32'd32768;
         3, 4:    return SAMPLE_W'($urandom_range(0, 131071)) - 32'd65536;
         5:       return SAMPLE_W'($urandom_range(0, 1 << 24)) - 32'd8388608;
         6:       return $urandom;
         7: begin
            case ($urandom_range(0, 5))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_7FFF;
               3:       return 32'hFFFF_8000;
               4:       return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
         default: return SAMPLE_W'($urandom_range(0, 2047)) - 32'd1024;
      endcase
   endfunction

   // one input transaction; the prediction is taken when it is accepted
   task automatic send_sample(logic [SAMPLE_W-1:0] sample, bit use_typed,
                              clip_result_t typed);
      int           gap;
      clip_result_t predicted;
      if ($urandom_range(0, 63) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mixed_sample <= sample;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = scale_and_track(sample);
      expected_outputs.push_back(use_typed ? typed : predicted);
      items_sent++;
   endtask

   // register write once the block has drained and finished any gain update
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_FRAMES: cfg_frames = data[FRAMES_W-1:0];
         CSR_RETAIN: cfg_retain = data[RETAIN_W-1:0];
         CSR_WEIGHT: cfg_weight = data[WEIGHT_W-1:0];
         default: ;
      endcase
      cfg_writes++;
   endtask

   // new settings for a random phase, extremes included
   task automatic random_settings();
      logic [CSR_DATA_W-1:0] frames;
      case ($urandom_range(0, 9))
         0:       frames = '0;
         1:       frames = CSR_DATA_W'(MAX_CHUNK_FRAMES);
         2:       frames = CSR_DATA_W'(8191);
         3:       frames = CSR_DATA_W'($urandom_range(1, 64));
         default: frames = CSR_DATA_W'($urandom_range(1, 8));
      endcase
      write_reg(CSR_FRAMES, frames);
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_RETAIN, '0);
            1:       write_reg(CSR_RETAIN, CSR_DATA_W'(255));
            default: write_reg(CSR_RETAIN, CSR_DATA_W'($urandom_range(0, 255)));
         endcase
      end
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_WEIGHT, '0);
            1:       write_reg(CSR_WEIGHT, CSR_DATA_W'(65535));
            default: write_reg(CSR_WEIGHT, CSR_DATA_W'($urandom_range(0, 65535)));
         endcase
      end
   endtask

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      clip_result_t want;
      results_seen++;
      if (expected_outputs.size() == 0) begin
         mismatches++;
         $display("%0t ns: result transaction with nothing expected, actual sample %0d",
                  $time, rsp_clipped_sample);
      end else begin
         want = expected_outputs.pop_front();
         compare_field("clipped_sample", longint'($signed(want.clipped)),
                       longint'(rsp_clipped_sample));
         compare_field("chunk_end", want.chunk_end, rsp_chunk_end);
         compare_field("chunk_peak", want.peak, rsp_chunk_peak);
         compare_field("meter_level", want.meter, rsp_meter_level);
         compare_field("meter_valid", want.meter_valid, rsp_meter_valid);
         compare_field("gain_now", want.gain, rsp_gain_now);
         if (want.chunk_end) chunk_ends++;
         if (want.meter_valid) meter_updates++;
         if (want.clipped == SAMPLE_MAX || want.clipped == SAMPLE_MIN) saturated++;
      end
   endtask

   // result side with random back-pressure
   initial begin
      int stall;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 63) == 0) rsp_quiet = !rsp_quiet;
         stall = rsp_quiet ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         check_result();
      end
   end

   // stimulus: directed table, then random phases
   initial begin
      int        n;
      int        rand_items;
      stim_row_t row;
      rand_items = 0;
      foreach (peak_log[i]) peak_log[i] = '0;

      // after reset: unity gain, extremes and the saturation edges
      add_row(ROW_TYPED, CSR_FRAMES, 32'h0000_0000, unity_result(0, 0));
      add_row(ROW_TYPED, CSR_FRAMES, 32'h0000_0001, unity_result(1, 1));
      add_row(ROW_TYPED, CSR_FRAMES, 32'hFFFF_FFFF, unity_result(-1, 1));
      add_row(ROW_TYPED, CSR_FRAMES, 32'h0000_7FFF, unity_result(32767, 32767));
      add_row(ROW_TYPED, CSR_FRAMES, 32'hFFFF_8000, unity_result(-32768, 32767));
      add_row(ROW_TYPED, CSR_FRAMES, 32'h0000_8000, unity_result(32767, 32767));
      add_row(ROW_TYPED, CSR_FRAMES, 32'hFFFF_7FFF, unity_result(-32768, 32767));
      add_row(ROW_TYPED, CSR_FRAMES, 32'h7FFF_FFFF, unity_result(32767, 32767));
      add_row(ROW_TYPED, CSR_FRAMES, 32'h8000_0000, unity_result(-32768, 32767));
      // shrink to one frame mid-chunk, heavy weight: gain collapses to zero
      add_row(ROW_CSR, CSR_FRAMES, 32'd1, '0);
      add_row(ROW_CSR, CSR_RETAIN, 32'd0, '0);
      add_row(ROW_CSR, CSR_WEIGHT, 32'd65535, '0);
      add_row(ROW_SAMPLE, CSR_FRAMES, 32'h7FFF_FFFF, '0);
      add_row(ROW_SAMPLE, CSR_FRAMES, 32'h1234_5678, '0);
      add_row(ROW_SAMPLE, CSR_FRAMES, 32'h8000_0000, '0);
      // zero frames behaves as one
      add_row(ROW_CSR, CSR_FRAMES, 32'd0, '0);
      add_row(ROW_SAMPLE, CSR_FRAMES, 32'h0000_4000, '0);
      add_row(ROW_SAMPLE, CSR_FRAMES, 32'hFFFF_C000, '0);
      // slow recovery, oversize frame count, then shrink again
      add_row(ROW_CSR, CSR_RETAIN, 32'd255, '0);
      add_row(ROW_CSR, CSR_WEIGHT, 32'd0, '0);
      add_row(ROW_CSR, CSR_FRAMES, 32'd8191, '0);
      add_row(ROW_SAMPLE, CSR_FRAMES, 32'h0001_0000, '0);
      add_row(ROW_SAMPLE, CSR_FRAMES, 32'h0000_1234, '0);
      add_row(ROW_SAMPLE, CSR_FRAMES, 32'h7FFF_0000, '0);
      add_row(ROW_CSR, CSR_FRAMES, 32'd1, '0);
      // enough short chunks to complete the peak history
      for (int i = 0; i < 9; i++) add_row(ROW_SAMPLE, CSR_FRAMES, 32'h0000_0100 << i, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[k]) begin
         row = stim_table[k];
         case (row.kind)
            ROW_CSR:   write_reg(row.idx, row.value[CSR_DATA_W-1:0]);
            ROW_TYPED: send_sample(row.value, 1'b1, row.typed);
            default:   send_sample(row.value, 1'b0, '0);
         endcase
      end
      directed_items = items_sent;

      while (rand_items < RANDOM_ITEMS) begin
         random_settings();
         if (cfg_frames > FRAMES_W'(64)) n = $urandom_range(10, 40);
         else n = $urandom_range(30, 150);
         repeat (n) begin
            send_sample(random_sample(), 1'b0, '0);
            rand_items++;
         end
      end
      req_valid <= 1'b0;

      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run: %0d sample transactions (%0d directed), %0d results, %0d saturated",
               items_sent, directed_items, results_seen, saturated);
      $display("run: %0d chunk ends, %0d meter updates, %0d register writes, %0d mismatches",
               chunk_ends, meter_updates, cfg_writes, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_NS);
      $display("timeout with %0d results still expected", expected_outputs.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
rtl/agac_pkg.sv
rtl/agac_ctrl.sv
rtl/agac_dpath.sv
rtl/adaptive_gain_audio_clipper.sv
dv/tb_top.sv
